[rtl/sbq_pkg.sv]
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants for the stereo biquad equalizer cascade.
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int NumSections  = 4;
  localparam int SampleBits   = 24;
  localparam int CoefBits     = 32;
  localparam int CoefFracBits = 27;
  localparam int GuardBits    = 8;
  localparam int WideBits     = SampleBits + GuardBits;
  localparam int NumSlots     = 5;
  localparam int SecBits      = (NumSections > 1) ? $clog2(NumSections) : 1;
  localparam int ProdBits     = CoefBits + WideBits;
  localparam int AccBits      = ProdBits + 3;

  typedef enum logic [1:0] {
    OP_PROCESS = 2'd0,
    OP_WRITE   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } slot_e;

  typedef logic signed [CoefBits-1:0] coef_t;
  typedef logic signed [WideBits-1:0] wide_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coefs_t;

  // lane control from the sequencer
  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctl_t;

  // round half up at sample grid, saturate to guard width
  function automatic wide_t round_sat(input logic signed [AccBits-1:0] a);
    logic signed [AccBits-1:0] r;
    logic signed [AccBits-1:0] mx;
    logic signed [AccBits-1:0] mn;
    r  = (a + (AccBits'(1) <<< (CoefFracBits - 1))) >>> CoefFracBits;
    mx = AccBits'((64'(1) << (WideBits - 1)) - 64'(1));
    mn = -mx - AccBits'(1);
    if (r > mx) return mx[WideBits-1:0];
    if (r < mn) return mn[WideBits-1:0];
    return r[WideBits-1:0];
  endfunction

endpackage

[rtl/sbq_lane.sv]
// ----------------------------------------------------------------------------
// sbq_lane
// One channel of the cascade: sections run in turn on a shared multiplier.
// ----------------------------------------------------------------------------
module sbq_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sbq_pkg::lane_ctl_t      ctl_i,
  input  sbq_pkg::wide_t          x_i,
  input  sbq_pkg::coefs_t         coefs_i,
  output logic [sbq_pkg::SecBits-1:0] sec_o,
  output logic                    done_o,
  output sbq_pkg::wide_t          y_o
);

  localparam int P = sbq_pkg::ProdBits;
  localparam int A = sbq_pkg::AccBits;

  // eight phases per section: 0 b0*x, 1 round y, 2 b1*x, 3 a1*y, 4 b2*x,
  // 5 a2*y and store d0, 6 finish d1 sum, 7 store d1 and move on
  logic [2:0] ph_q, ph_d;
  logic       busy_q, busy_d;
  logic [sbq_pkg::SecBits-1:0] sec_q, sec_d;
  sbq_pkg::wide_t x_q, x_d, y_q, y_d;
  logic signed [A-1:0] acc_q, acc_d;
  logic signed [P-1:0] prod_q;
  sbq_pkg::wide_t d0_q [sbq_pkg::NumSections];
  sbq_pkg::wide_t d1_q [sbq_pkg::NumSections];
  logic done_q;

  sbq_pkg::coef_t mc;
  sbq_pkg::wide_t mx;
  logic signed [A-1:0] dsc;

  always_comb begin
    case (ph_q)
      3'd0:    begin mc = coefs_i.b0; mx = x_q; end
      3'd2:    begin mc = coefs_i.b1; mx = x_q; end
      3'd3:    begin mc = coefs_i.a1; mx = y_q; end
      3'd4:    begin mc = coefs_i.b2; mx = x_q; end
      default: begin mc = coefs_i.a2; mx = y_q; end
    endcase
  end

  always_ff @(posedge clk_i) prod_q <= P'(mc) * P'(mx);

  // multiplier output is registered in prod_q
  always_comb begin
    ph_d   = ph_q;
    busy_d = busy_q;
    sec_d  = sec_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    dsc    = '0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      ph_d   = '0;
      sec_d  = '0;
      x_d    = x_i;
    end else if (busy_q) begin
      ph_d = ph_q + 3'd1;
      unique case (ph_q)
        3'd0: ;
        3'd1: begin
          dsc = A'(d0_q[sec_q]) <<< sbq_pkg::CoefFracBits;
          y_d = sbq_pkg::round_sat(A'(prod_q) + dsc);
        end
        3'd2: ;
        3'd3: begin
          dsc   = A'(d1_q[sec_q]) <<< sbq_pkg::CoefFracBits;
          acc_d = A'(prod_q) + dsc;
        end
        3'd4: acc_d = acc_q - A'(prod_q);
        3'd5: acc_d = A'(prod_q);
        3'd6: acc_d = acc_q - A'(prod_q);
        default: begin
          ph_d = '0;
          x_d  = y_q;
          if (32'(sec_q) == sbq_pkg::NumSections - 1) busy_d = 1'b0;
          else sec_d = sec_q + sbq_pkg::SecBits'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= '0;
      busy_q <= 1'b0;
      sec_q  <= '0;
      done_q <= 1'b0;
      for (int i = 0; i < sbq_pkg::NumSections; i++) begin
        d0_q[i] <= '0;
        d1_q[i] <= '0;
      end
    end else begin
      ph_q   <= ph_d;
      busy_q <= busy_d;
      sec_q  <= sec_d;
      done_q <= busy_q && !busy_d;
      if (ctl_i.clear) begin
        for (int i = 0; i < sbq_pkg::NumSections; i++) begin
          d0_q[i] <= '0;
          d1_q[i] <= '0;
        end
      end else if (busy_q && ph_q == 3'd5) begin
        d0_q[sec_q] <= sbq_pkg::round_sat(acc_q);
      end else if (busy_q && ph_q == 3'd7) begin
        d1_q[sec_q] <= sbq_pkg::round_sat(acc_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign sec_o  = sec_q;
  assign done_o = done_q;
  assign y_o    = x_q;

endmodule

[rtl/stereo_biquad_eq_cascade_unit.sv]
// ----------------------------------------------------------------------------
// stereo_biquad_eq_cascade_unit
// Stereo cascade of biquad sections in transposed direct form II.
// ----------------------------------------------------------------------------
// A process request runs the default four sections in turn in each of two
// channel lanes that run side by side; each lane has one 32x32 multiplier that
// does its five products per section in turn. Coefficient writes and clears
// give no result. Results sit in an output register; a new request is taken
// once the lanes are idle and that register is empty, so requests do not
// overlap: a new one waits until the last result has left that register.
module stereo_biquad_eq_cascade_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic signed [23:0]  left_in_i,
  input  logic signed [23:0]  right_in_i,
  input  logic                mono_i,
  input  logic [1:0]          band_index_i,
  input  logic [2:0]          coef_slot_i,
  input  logic signed [31:0]  coef_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [23:0]  left_out_o,
  output logic signed [23:0]  right_out_o
);

  localparam int SB = sbq_pkg::SampleBits;

  // shared coefficient table, reset to passthrough
  sbq_pkg::coefs_t coef_q [sbq_pkg::NumSections];
  logic busy_q;
  logic out_valid_q;
  logic signed [SB-1:0] lo_q, ro_q;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  // hold off while the lanes run or a result still waits
  assign in_stall_o = busy_q || out_valid_q;

  sbq_pkg::lane_ctl_t ctl;
  assign ctl.start = accept && (operation_i == sbq_pkg::OP_PROCESS);
  assign ctl.clear = accept && (operation_i == sbq_pkg::OP_CLEAR);

  logic [sbq_pkg::SecBits-1:0] secl, secr;
  logic doner, donel;
  sbq_pkg::wide_t yl, yr, xl, xr;

  assign xl = sbq_pkg::WideBits'(left_in_i);
  assign xr = mono_i ? xl : sbq_pkg::WideBits'(right_in_i);

  sbq_lane u_left (
    .clk_i, .rst_ni, .ctl_i(ctl), .x_i(xl), .coefs_i(coef_q[secl]),
    .sec_o(secl), .done_o(donel), .y_o(yl)
  );
  sbq_lane u_right (
    .clk_i, .rst_ni, .ctl_i(ctl), .x_i(xr), .coefs_i(coef_q[secr]),
    .sec_o(secr), .done_o(doner), .y_o(yr)
  );

  function automatic logic signed [SB-1:0] sat_out(input sbq_pkg::wide_t v);
    if (v > sbq_pkg::wide_t'((1 << (SB - 1)) - 1)) return {1'b0, {(SB-1){1'b1}}};
    if (v < -sbq_pkg::wide_t'(1 << (SB - 1)))     return {1'b1, {(SB-1){1'b0}}};
    return v[SB-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < sbq_pkg::NumSections; i++) begin
        coef_q[i] <= '{b0: sbq_pkg::coef_t'(1) <<< sbq_pkg::CoefFracBits,
                       b1: '0, b2: '0, a1: '0, a2: '0};
      end
    end else begin
      // merge: both lanes finish together; the output register is free here
      if (busy_q && donel && doner) begin
        out_valid_q <= 1'b1;
        busy_q      <= 1'b0;
      end else begin
        if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
        if (ctl.start) busy_q <= 1'b1;
      end
      if (accept && operation_i == sbq_pkg::OP_WRITE &&
          32'(band_index_i) < sbq_pkg::NumSections) begin
        unique case (coef_slot_i)
          sbq_pkg::SLOT_B0: coef_q[band_index_i[sbq_pkg::SecBits-1:0]].b0 <= coef_value_i;
          sbq_pkg::SLOT_B1: coef_q[band_index_i[sbq_pkg::SecBits-1:0]].b1 <= coef_value_i;
          sbq_pkg::SLOT_B2: coef_q[band_index_i[sbq_pkg::SecBits-1:0]].b2 <= coef_value_i;
          sbq_pkg::SLOT_A1: coef_q[band_index_i[sbq_pkg::SecBits-1:0]].a1 <= coef_value_i;
          sbq_pkg::SLOT_A2: coef_q[band_index_i[sbq_pkg::SecBits-1:0]].a2 <= coef_value_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && donel && doner) begin
      lo_q <= sat_out(yl);
      ro_q <= sat_out(yr);
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = lo_q;
  assign right_out_o = ro_q;

`ifndef NO_ASSERTIONS
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    donel == doner) else $error("lanes out of step");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !ctl.start) else $error("start while busy");
`endif

endmodule
